FILE: rtl/core/msgp_pkg.sv
// ----------------------------------------------------------------------------
// msgp_pkg: shared types and constants of the gradient palette core
// Stop table geometry, item kinds, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package msgp_pkg;

  localparam int STOP_COUNT  = 8;
  localparam int SLOT_W      = 3;
  localparam int POS_W       = 9;
  localparam int COL_W       = 8;
  localparam int IDX_W       = 8;
  localparam int NUM_CHAN    = 3;
  localparam int NUM_W       = 2 * COL_W;       // blended numerator
  localparam int PROD_W      = COL_W + POS_W;   // one weighted product
  localparam int QUOT_W      = COL_W;           // quotient never exceeds 255
  localparam int FIXED_STOPS = 2;
  localparam int CNT_W       = (SLOT_W > 3) ? SLOT_W : 3;

  localparam logic [POS_W-1:0] PAL_SIZE   = POS_W'(256);
  localparam logic [POS_W-1:0] UNUSED_POS = POS_W'(257);

  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(STOP_COUNT - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUOT_W - 1);

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } msgp_state_t;

  typedef struct packed {
    logic             accept;   // take the item at the input
    logic             scan;     // examine one stop slot
    logic             mul;      // form numerators and span
    logic             div;      // one restoring division step
    logic             load;     // move the result into the output register
    logic [CNT_W-1:0] step;     // slot under scan
  } msgp_cmd_t;

  typedef struct packed {
    logic out_free;             // output register can take a result now
  } msgp_sts_t;

endpackage

FILE: rtl/core/msgp_if.sv
// ----------------------------------------------------------------------------
// msgp_if: valid/ready channels of the gradient palette core
// Input item channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface msgp_in_if import msgp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [SLOT_W-1:0]    slot;
  logic [POS_W-1:0]     position;
  logic [COL_W-1:0]     stop_red;
  logic [COL_W-1:0]     stop_green;
  logic [COL_W-1:0]     stop_blue;
  logic [IDX_W-1:0]     index;

  modport source (output valid, kind, slot, position, stop_red, stop_green,
                  stop_blue, index, input ready);
  modport sink   (input valid, kind, slot, position, stop_red, stop_green,
                  stop_blue, index, output ready);
endinterface

interface msgp_out_if import msgp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] pal_red;
  logic [COL_W-1:0] pal_green;
  logic [COL_W-1:0] pal_blue;

  modport source (output valid, pal_red, pal_green, pal_blue, input ready);
  modport sink   (input valid, pal_red, pal_green, pal_blue, output ready);
endinterface

FILE: rtl/core/msgp_ctrl.sv
// ----------------------------------------------------------------------------
// msgp_ctrl: sequencing controller
// Steps a lookup through scan, multiply and divide phases (a stop write skips
// them) and hands the result to the output register.
// ----------------------------------------------------------------------------
module msgp_ctrl import msgp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  input  msgp_sts_t  sts,
  output logic       in_ready,
  output msgp_cmd_t  cmd
);

  msgp_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = (in_kind == KIND_LOOKUP) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN: cmd.scan = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_DIV:  cmd.div  = 1'b1;
      ST_DONE: cmd.load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/msgp_dp.sv
// ----------------------------------------------------------------------------
// msgp_dp: stop table and interpolation datapath
// Holds the stops, scans them for the enclosing pair, blends and divides
// the three channels in parallel, and keeps the output register.
// ----------------------------------------------------------------------------
module msgp_dp import msgp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  msgp_cmd_t         cmd,
  output msgp_sts_t         sts,
  input  logic              in_kind,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [POS_W-1:0]  in_position,
  input  logic [COL_W-1:0]  in_stop_red,
  input  logic [COL_W-1:0]  in_stop_green,
  input  logic [COL_W-1:0]  in_stop_blue,
  input  logic [IDX_W-1:0]  in_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  out_pal_red,
  output logic [COL_W-1:0]  out_pal_green,
  output logic [COL_W-1:0]  out_pal_blue
);

  typedef logic [NUM_CHAN-1:0][COL_W-1:0] colour_t;

  logic [POS_W-1:0] pos_r [STOP_COUNT];
  colour_t          col_r [STOP_COUNT];

  logic [IDX_W-1:0] idx_r;
  logic             have_s_r, have_e_r;
  logic [POS_W-1:0] s_pos_r, e_pos_r, span_r;
  colour_t          s_col_r, e_col_r;
  logic [POS_W-1:0] rem_r [NUM_CHAN];
  logic [QUOT_W-1:0] lo_r [NUM_CHAN];

  logic             out_valid_r;
  colour_t          out_col_r;

  logic [POS_W-1:0] rd_pos;
  colour_t          rd_col;
  logic             in_range, below, take_s, take_e;
  logic [POS_W-1:0] off, span, wgt_s, wr_pos;
  logic [NUM_W-1:0] num [NUM_CHAN];
  logic [POS_W:0]   trial [NUM_CHAN];
  logic [POS_W:0]   diff  [NUM_CHAN];
  logic             ge    [NUM_CHAN];
  logic             wr_en;

  // scan: one slot per cycle
  always_comb begin
    rd_pos   = pos_r[cmd.step[SLOT_W-1:0]];
    rd_col   = col_r[cmd.step[SLOT_W-1:0]];
    in_range = (rd_pos <= PAL_SIZE);
    below    = (rd_pos <= {1'b0, idx_r});
    take_s   = in_range && below  && (!have_s_r || rd_pos >= s_pos_r);
    take_e   = in_range && !below && (!have_e_r || rd_pos < e_pos_r);
  end

  // blend numerators: start*(span-off) + end*off, never above 255*256
  always_comb begin
    off   = {1'b0, idx_r} - s_pos_r;
    span  = e_pos_r - s_pos_r;
    wgt_s = span - off;
    for (int c = 0; c < NUM_CHAN; c++) begin
      num[c] = NUM_W'(PROD_W'(s_col_r[c]) * PROD_W'(wgt_s)
                    + PROD_W'(e_col_r[c]) * PROD_W'(off));
    end
  end

  // restoring division trial, one quotient bit per step
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      trial[c] = {rem_r[c], lo_r[c][QUOT_W-1]};
      diff[c]  = trial[c] - {1'b0, span_r};
      ge[c]    = (trial[c] >= {1'b0, span_r});
    end
  end

  assign wr_en  = cmd.accept && (in_kind == KIND_WRITE)
                  && (int'(in_slot) < STOP_COUNT);
  assign wr_pos = (in_position > UNUSED_POS) ? UNUSED_POS : in_position;

  // stop table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STOP_COUNT; i++) begin
        pos_r[i] <= (i == 0) ? '0 : ((i == 1) ? PAL_SIZE : UNUSED_POS);
        col_r[i] <= (i == 0) ? '0 : '1;
      end
    end else if (wr_en) begin
      col_r[in_slot] <= {in_stop_red, in_stop_green, in_stop_blue};
      if (int'(in_slot) >= FIXED_STOPS) begin
        pos_r[in_slot] <= wr_pos;
      end
    end
  end

  // search flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_s_r <= 1'b0;
      have_e_r <= 1'b0;
    end else if (cmd.accept) begin
      have_s_r <= 1'b0;
      have_e_r <= 1'b0;
    end else if (cmd.scan) begin
      if (take_s) have_s_r <= 1'b1;
      if (take_e) have_e_r <= 1'b1;
    end
  end

  // search payload, numerators and division
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_index;
    end
    if (cmd.scan) begin
      if (take_s) begin
        s_pos_r <= rd_pos;
        s_col_r <= rd_col;
      end
      if (take_e) begin
        e_pos_r <= rd_pos;
        e_col_r <= rd_col;
      end
    end
    if (cmd.mul) begin
      span_r <= span;
      for (int c = 0; c < NUM_CHAN; c++) begin
        rem_r[c] <= POS_W'(num[c][NUM_W-1:QUOT_W]);
        lo_r[c]  <= num[c][QUOT_W-1:0];
      end
    end
    if (cmd.div) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        rem_r[c] <= ge[c] ? diff[c][POS_W-1:0] : trial[c][POS_W-1:0];
        lo_r[c]  <= {lo_r[c][QUOT_W-2:0], ge[c]};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        out_col_r[c] <= (have_s_r && have_e_r) ? lo_r[c] : '0;
      end
    end
  end

  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_pal_red   = out_col_r[2];
  assign out_pal_green = out_col_r[1];
  assign out_pal_blue  = out_col_r[0];

endmodule

FILE: rtl/core/multi_stop_gradient_palette_core.sv
// ----------------------------------------------------------------------------
// multi_stop_gradient_palette_core: multi-stop linear gradient palette
// Keeps eight colour stops and answers palette lookups by linear
// interpolation between the enclosing stops with an exact integer floor.
// ----------------------------------------------------------------------------
// Lookup: the beat is taken in the idle state, the stop slots are scanned one after
//   the other, the multiply state forms the numerators and span, 8 restoring
//   divide steps run for the three channels side by side, and the done state
//   loads the output register; only then is the next beat taken.
// Stop write: skips scan, multiply and divide; its result beat carries zero colour.
// A finished result waits in the output register while the next beat runs.
// Reset (synchronous, active low) restores the default stops: black at 0,
//   white at 256, all other slots unused, and empties the output register.
// ----------------------------------------------------------------------------
module multi_stop_gradient_palette_core import msgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  msgp_in_if.sink     in_bus,
  msgp_out_if.source  out_bus
);

  msgp_cmd_t cmd;
  msgp_sts_t sts;

  // Controller: walks the phases, owns the input ready.
  msgp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_kind  (in_bus.kind),
    .sts      (sts),
    .in_ready (in_bus.ready),
    .cmd      (cmd)
  );

  // Datapath: stop table, pair search, blend, divide, output register.
  msgp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_bus.kind),
    .in_slot       (in_bus.slot),
    .in_position   (in_bus.position),
    .in_stop_red   (in_bus.stop_red),
    .in_stop_green (in_bus.stop_green),
    .in_stop_blue  (in_bus.stop_blue),
    .in_index      (in_bus.index),
    .out_valid     (out_bus.valid),
    .out_ready     (out_bus.ready),
    .out_pal_red   (out_bus.pal_red),
    .out_pal_green (out_bus.pal_green),
    .out_pal_blue  (out_bus.pal_blue)
  );

  // Never overwrite a result beat that has not been taken.
  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_bus.valid || out_bus.ready))
    else $error("result loaded over a pending beat");

  // A write beat into an empty output side yields its result through the done state and the output register.
  a_write_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && (in_bus.kind == KIND_WRITE)
     && !out_bus.valid) |-> ##2 out_bus.valid)
    else $error("write beat result missing");

  // A new result beat only appears after the controller loaded one.
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(cmd.load))
    else $error("result beat without load");

  // No new item is taken while the datapath scans, multiplies or divides.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan || cmd.mul || cmd.div) |-> !in_bus.ready)
    else $error("input ready during item processing");

endmodule

FILE: test/msgp_palette_checker.sv
// ----------------------------------------------------------------------------
// msgp_palette_checker: result checker for the gradient palette core
// Watches the item and result channels, keeps its own copy of the stop table,
// predicts the colour of every accepted beat and compares it with the result
// beats in order. Hands the mismatch and outstanding counts to the bench top.
// ----------------------------------------------------------------------------
module msgp_palette_checker import msgp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  msgp_in_if   in_mon,
  msgp_out_if  out_mon,
  output int   mismatch_count,
  output int   pending_count
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  logic [POS_W-1:0] stop_pos [STOP_COUNT];
  rgb_t             stop_rgb [STOP_COUNT];
  rgb_t             colour_due_q [$];

  // start + floor((end - start) * off / span), done as a weighted sum
  function automatic logic [COL_W-1:0] blend_channel(input logic [COL_W-1:0] from_c,
                                                     input logic [COL_W-1:0] to_c,
                                                     input logic [POS_W-1:0] off,
                                                     input logic [POS_W-1:0] span);
    logic [PROD_W:0] num;
    num = PROD_W'(from_c) * PROD_W'(span - off) + PROD_W'(to_c) * PROD_W'(off);
    return COL_W'(num / (PROD_W + 1)'(span));
  endfunction

  task automatic restore_stops();
    for (int i = 0; i < STOP_COUNT; i++) begin
      stop_pos[i] = (i == 0) ? '0 : ((i == 1) ? PAL_SIZE : UNUSED_POS);
      stop_rgb[i] = (i == 0) ? '0 : '1;
    end
    colour_due_q.delete();
  endtask

  task automatic predict_palette_beat();
    rgb_t             res;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] off;
    int               s;
    int               e;
    bit               have_s;
    bit               have_e;
    res = '0;
    if (in_mon.kind == KIND_WRITE) begin
      stop_rgb[in_mon.slot] = {in_mon.stop_red, in_mon.stop_green, in_mon.stop_blue};
      // end stops keep their positions, the rest take the written one, saturated to unused
      if (in_mon.slot >= FIXED_STOPS) begin
        stop_pos[in_mon.slot] = (in_mon.position > UNUSED_POS) ? UNUSED_POS
                                                               : in_mon.position;
      end
    end else begin
      idx = POS_W'(in_mon.index);
      have_s = 1'b0;
      have_e = 1'b0;
      s = 0;
      e = 0;
      for (int i = 0; i < STOP_COUNT; i++) begin
        if (stop_pos[i] <= PAL_SIZE) begin
          if (stop_pos[i] <= idx) begin
            if (!have_s || stop_pos[i] >= stop_pos[s]) begin
              s = i;
              have_s = 1'b1;
            end
          end else if (!have_e || stop_pos[i] < stop_pos[e]) begin
            e = i;
            have_e = 1'b1;
          end
        end
      end
      if (have_s && have_e) begin
        span = stop_pos[e] - stop_pos[s];
        off  = idx - stop_pos[s];
        res.red   = blend_channel(stop_rgb[s].red, stop_rgb[e].red, off, span);
        res.green = blend_channel(stop_rgb[s].green, stop_rgb[e].green, off, span);
        res.blue  = blend_channel(stop_rgb[s].blue, stop_rgb[e].blue, off, span);
      end
    end
    colour_due_q.push_back(res);
  endtask

  task automatic check_palette_beat();
    rgb_t got;
    rgb_t want;
    got = {out_mon.pal_red, out_mon.pal_green, out_mon.pal_blue};
    if (colour_due_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("result beat with nothing outstanding: r=%0d g=%0d b=%0d",
                 got.red, got.green, got.blue);
    end else begin
      want = colour_due_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("colour mismatch: r exp %0d got %0d, g exp %0d got %0d, b exp %0d got %0d",
                   want.red, got.red, want.green, got.green, want.blue, got.blue);
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    restore_stops();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      restore_stops();
    end else begin
      if (in_mon.valid && in_mon.ready) predict_palette_beat();
      if (out_mon.valid && out_mon.ready) check_palette_beat();
    end
    pending_count = colour_due_q.size();
  end

endmodule

FILE: test/tb_multi_stop_gradient_palette_core.sv
// ----------------------------------------------------------------------------
// tb_multi_stop_gradient_palette_core: bench for the gradient palette core
// Drives stop writes and palette lookups: a directed opening over the corner
// cases, then random beats under four idling phases and one long output
// hold-off. The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_multi_stop_gradient_palette_core import msgp_pkg::*; ();

  localparam int PHASE_BEATS   = 356;     // random beats per idling phase
  localparam int HOLD_CYCLES   = 300;     // long output hold-off
  localparam int SETTLE_CYCLES = 40;      // settle time after the last result
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic             kind;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0] position;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [IDX_W-1:0] index;
  } palette_beat_t;

  localparam int BEAT_W = $bits(palette_beat_t);

  logic clk;
  logic rst_n;

  msgp_in_if  in_bus ();
  msgp_out_if out_bus ();

  int mismatch_count;
  int pending_count;
  int cycle_count;

  // idling knobs, changed only at falling edges
  int idle_pct;
  int stall_pct;
  int idle_plan  [4] = '{0, 87, 0, 22};
  int stall_plan [4] = '{0, 0, 87, 22};
  logic pressure_go;
  logic hold_ready;

  multi_stop_gradient_palette_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  msgp_palette_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Build a stop write; the index field is don't-care, so fill it at random.
  function automatic palette_beat_t stop_write(input int slot, input int pos,
                                               input int r, input int g, input int b);
    palette_beat_t beat;
    beat.kind     = KIND_WRITE;
    beat.slot     = SLOT_W'(slot);
    beat.position = POS_W'(pos);
    beat.red      = COL_W'(r);
    beat.green    = COL_W'(g);
    beat.blue     = COL_W'(b);
    beat.index    = IDX_W'($urandom);
    return beat;
  endfunction

  // Build a lookup; the stop fields are don't-care, so fill them at random.
  function automatic palette_beat_t palette_lookup(input int idx);
    palette_beat_t beat;
    beat          = palette_beat_t'(BEAT_W'({$urandom, $urandom}));
    beat.kind     = KIND_LOOKUP;
    beat.index    = IDX_W'(idx);
    return beat;
  endfunction

  // Pick a channel value, leaning on the extremes now and then.
  function automatic int rand_channel();
    case ($urandom_range(6))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Offer one beat from a falling edge; return at the falling edge after
  // the beat was taken. Idle cycles come first, so valid moves once per step.
  task automatic offer_beat(input palette_beat_t beat);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.kind       <= beat.kind;
    in_bus.slot       <= beat.slot;
    in_bus.position   <= beat.position;
    in_bus.stop_red   <= beat.red;
    in_bus.stop_green <= beat.green;
    in_bus.stop_blue  <= beat.blue;
    in_bus.index      <= beat.index;
    in_bus.valid      <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Receiver: decide at the rising edge, drive at the falling edge. Hold ready
  // low outright while the long hold-off runs.
  initial begin
    logic take;
    forever begin
      @(posedge clk);
      take = !hold_ready && ($urandom_range(99) >= stall_pct);
      @(negedge clk);
      out_bus.ready <= take;
    end
  end

  // Long hold-off: count it out in falling edges once the main flow asks.
  initial begin
    hold_ready = 1'b0;
    wait (pressure_go);
    @(negedge clk);
    hold_ready = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_ready = 1'b0;
  end

  // Watchdog: end the run with a mismatch report once the cycle limit is reached.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    palette_beat_t beat;
    int            idx;
    int            pos;

    // Drive every input to a known value before the first edge.
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.kind       = KIND_WRITE;
    in_bus.slot       = '0;
    in_bus.position   = '0;
    in_bus.stop_red   = '0;
    in_bus.stop_green = '0;
    in_bus.stop_blue  = '0;
    in_bus.index      = '0;
    out_bus.ready     = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    pressure_go       = 1'b0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: default gradient, both ends and the middle.
    offer_beat(palette_lookup(0));
    offer_beat(palette_lookup(255));
    offer_beat(palette_lookup(128));
    // End stops: position fields are ignored, only the colour changes.
    offer_beat(stop_write(0, 300, 255, 0, 128));
    offer_beat(stop_write(1, 0, 0, 255, 127));
    offer_beat(palette_lookup(0));
    offer_beat(palette_lookup(255));
    // Middle stop and its neighbours.
    offer_beat(stop_write(2, 128, 18, 52, 86));
    offer_beat(palette_lookup(127));
    offer_beat(palette_lookup(128));
    offer_beat(palette_lookup(129));
    // Tie at 128: the later slot starts, the earlier slot ends.
    offer_beat(stop_write(3, 128, 170, 187, 204));
    offer_beat(palette_lookup(128));
    offer_beat(palette_lookup(127));
    // Tie with the fixed stop at 0.
    offer_beat(stop_write(4, 0, 1, 2, 3));
    offer_beat(palette_lookup(0));
    // Oversized position saturates to unused; an explicit unused one too.
    offer_beat(stop_write(5, 511, 255, 255, 255));
    offer_beat(stop_write(6, 257, 9, 9, 9));
    offer_beat(palette_lookup(200));
    // Tie with the fixed stop at 256, and a stop right below it.
    offer_beat(stop_write(7, 256, 0, 0, 0));
    offer_beat(stop_write(6, 255, 255, 255, 255));
    offer_beat(palette_lookup(255));
    // Drop a stop again and look across the gap.
    offer_beat(stop_write(2, 257, 0, 0, 0));
    offer_beat(palette_lookup(128));

    // Random part, one idling phase after the other.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Start the long hold-off early in the free-running phase.
        if (p == 0 && n == 20) pressure_go = 1'b1;
        if ($urandom_range(99) < 35) begin
          case ($urandom_range(9))
            0:       pos = 257;
            1:       pos = $urandom_range(511, 258);
            2:       begin
              case ($urandom_range(4))
                0:       pos = 0;
                1:       pos = 64;
                2:       pos = 128;
                3:       pos = 255;
                default: pos = 256;
              endcase
            end
            default: pos = $urandom_range(256);
          endcase
          beat = stop_write($urandom_range(STOP_COUNT - 1), pos,
                            rand_channel(), rand_channel(), rand_channel());
        end else begin
          if ($urandom_range(9) == 0) idx = $urandom_range(1) ? 255 : 0;
          else idx = $urandom_range(255);
          beat = palette_lookup(idx);
        end
        offer_beat(beat);
      end
    end

    // Drain: drop valid, wait for the last result, then let the core settle.
    in_bus.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/msgp_pkg.sv
rtl/core/msgp_if.sv
rtl/core/msgp_ctrl.sv
rtl/core/msgp_dp.sv
rtl/core/multi_stop_gradient_palette_core.sv
test/msgp_palette_checker.sv
test/tb_multi_stop_gradient_palette_core.sv
